// ----- rtl/dspad_pkg.sv -----
package dspad_pkg;

    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 2;
    localparam int COEF_W   = 16;
    localparam int PAIR_W   = 2 * COEF_W;
    localparam int NUM_PRED = 8;
    localparam int PRED_W   = $clog2(NUM_PRED);
    localparam int SHIFT_W  = 4;
    localparam int FRAC_W   = 11;
    // nibble * 2^15 * 2^11 plus two 16x16 products and rounding fit in 34 bits
    localparam int ACC_W    = 34;

    localparam logic [CMD_W-1:0] CMD_HEADER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1024);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // control word from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic load;   // 1: start from base, 0: add to running sum
    } mac_ctrl_t;

endpackage

// ----- rtl/dspad_if.sv -----
interface dspad_in_if
    import dspad_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [BYTE_W-1:0]          data_byte;
    logic signed [SAMPLE_W-1:0] init_newer;
    logic signed [SAMPLE_W-1:0] init_older;

    modport source (output valid, output cmd, output data_byte, output init_newer,
                    output init_older, input ready);
    modport sink (input valid, input cmd, input data_byte, input init_newer,
                  input init_older, output ready);
endinterface

interface dspad_out_if
    import dspad_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_high;
    logic signed [SAMPLE_W-1:0] sample_low;
    logic                       coef_error;

    modport source (output valid, output sample_high, output sample_low,
                    output coef_error, input ready);
    modport sink (input valid, input sample_high, input sample_low,
                  input coef_error, output ready);
endinterface

// ----- rtl/dsp_adpcm_decoder_core.sv -----
// A data word runs through states MUL1, MUL2, MUL3, MUL4 and FIN; FIN registers
// its result once the output register is free. Only then is a new word taken;
// the shared 16x16 multiply-accumulate unit makes four passes per data word
// (two per sample). Header and history-load words give no result.
// Reset (rst_n low, asynchronous) clears history, header state and coefficients.
module dsp_adpcm_decoder_core
    import dspad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    dspad_in_if.sink           item,
    dspad_out_if.source        result,
    input  logic               cfg_wr_en,
    input  logic [PRED_W-1:0]  cfg_index,
    input  logic [PAIR_W-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_FIN
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [SAMPLE_W-1:0] hist_newer_reg, hist_newer_next;
    logic signed [SAMPLE_W-1:0] hist_older_reg, hist_older_next;
    logic [SHIFT_W-1:0]         scale_shift_reg, scale_shift_next;
    logic [PRED_W-1:0]          pred_select_reg, pred_select_next;
    logic                       bad_index_reg, bad_index_next;
    logic [BYTE_W-1:0]          data_reg, data_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_high_reg, sample_high_next;
    logic signed [SAMPLE_W-1:0] sample_low_reg, sample_low_next;
    logic                       coef_error_reg, coef_error_next;

    logic                       accept;
    logic [PAIR_W-1:0]          pair;
    logic signed [COEF_W-1:0]   c1;
    logic signed [COEF_W-1:0]   c2;
    mac_ctrl_t                  mac_ctrl;
    logic signed [COEF_W-1:0]   op_a;
    logic signed [SAMPLE_W-1:0] op_b;
    logic [3:0]                 nib;
    logic signed [ACC_W-1:0]    base;
    logic signed [SAMPLE_W-1:0] mac_sample;

    dspad_coef_regs u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sel       (pred_select_reg),
        .pair      (pair)
    );

    assign c1 = pair[PAIR_W-1:COEF_W];
    assign c2 = pair[COEF_W-1:0];

    dspad_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .op_a   (op_a),
        .op_b   (op_b),
        .base   (base),
        .sample (mac_sample)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    assign result.valid       = out_valid_reg;
    assign result.sample_high = sample_high_reg;
    assign result.sample_low  = sample_low_reg;
    assign result.coef_error  = coef_error_reg;

    // scaled nibble term plus rounding half: nib * 2^(shift+11) + 1024
    always_comb
    begin
        nib  = (state_reg == ST_MUL1) ? data_reg[7:4] : data_reg[3:0];
        base = (ACC_W'($signed(nib)) <<< (5'(scale_shift_reg) + 5'(FRAC_W))) + ROUND_HALF;
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mac_ctrl = '0;
        op_a     = c1;
        op_b     = hist_newer_reg;
        unique case (state_reg)
            ST_MUL1:
            begin
                mac_ctrl = '{en: 1'b1, load: 1'b1};
                op_a     = c1;
                op_b     = hist_newer_reg;
            end
            ST_MUL2:
            begin
                mac_ctrl = '{en: 1'b1, load: 1'b0};
                op_a     = c2;
                op_b     = hist_older_reg;
            end
            ST_MUL3:
            begin
                // second sample's older tap is the current newer sample
                mac_ctrl = '{en: 1'b1, load: 1'b1};
                op_a     = c2;
                op_b     = hist_newer_reg;
            end
            ST_MUL4:
            begin
                // newer tap now holds the first sample
                mac_ctrl = '{en: 1'b1, load: 1'b0};
                op_a     = c1;
                op_b     = hist_newer_reg;
            end
            ST_IDLE, ST_FIN:
            begin
                mac_ctrl = '0;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // sequencer and state updates
    always_comb
    begin
        state_next       = state_reg;
        hist_newer_next  = hist_newer_reg;
        hist_older_next  = hist_older_reg;
        scale_shift_next = scale_shift_reg;
        pred_select_next = pred_select_reg;
        bad_index_next   = bad_index_reg;
        data_next        = data_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        sample_high_next = sample_high_reg;
        sample_low_next  = sample_low_reg;
        coef_error_next  = coef_error_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        CMD_HEADER:
                        begin
                            scale_shift_next = item.data_byte[3:0];
                            if (item.data_byte[7])
                            begin
                                pred_select_next = PRED_W'(NUM_PRED - 1);
                                bad_index_next   = 1'b1;
                            end
                            else
                            begin
                                pred_select_next = item.data_byte[6:4];
                                bad_index_next   = 1'b0;
                            end
                        end
                        CMD_DATA:
                        begin
                            data_next  = item.data_byte;
                            state_next = ST_MUL1;
                        end
                        CMD_LOAD:
                        begin
                            hist_newer_next = item.init_newer;
                            hist_older_next = item.init_older;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                hist_older_next = hist_newer_reg;
                hist_newer_next = mac_sample;
                state_next      = ST_MUL4;
            end
            ST_MUL4:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    hist_older_next  = hist_newer_reg;
                    hist_newer_next  = mac_sample;
                    out_valid_next   = 1'b1;
                    sample_high_next = hist_newer_reg;
                    sample_low_next  = mac_sample;
                    coef_error_next  = bad_index_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hist_newer_reg  <= '0;
            hist_older_reg  <= '0;
            scale_shift_reg <= '0;
            pred_select_reg <= '0;
            bad_index_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            hist_newer_reg  <= hist_newer_next;
            hist_older_reg  <= hist_older_next;
            scale_shift_reg <= scale_shift_next;
            pred_select_reg <= pred_select_next;
            bad_index_reg   <= bad_index_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg        <= data_next;
        sample_high_reg <= sample_high_next;
        sample_low_reg  <= sample_low_next;
        coef_error_reg  <= coef_error_next;
    end

    // a data word starts the multiply sequence
    a_data_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.cmd == CMD_DATA |=> state_reg == ST_MUL1)
        else $error("data word did not start the sequence");

    // a new result only comes out of the finish step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside finish step");

    // an out-of-range header index always falls back to the last predictor
    a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
        bad_index_reg |-> pred_select_reg == PRED_W'(NUM_PRED - 1))
        else $error("bad index without predictor clamp");

    // history shifts after the first sample
    a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL3 |=> hist_older_reg == $past(hist_newer_reg))
        else $error("history did not shift");

endmodule

// ----- rtl/dspad_coef_regs.sv -----
module dspad_coef_regs
    import dspad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [PRED_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0] cfg_wdata,
    input  logic [PRED_W-1:0] sel,
    output logic [PAIR_W-1:0] pair
);

    logic [PAIR_W-1:0] pair_reg [NUM_PRED];

    // predictor coefficient pairs, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PRED; i++)
            begin
                pair_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            pair_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign pair = pair_reg[sel];

endmodule

// ----- rtl/dspad_mac.sv -----
module dspad_mac
    import dspad_pkg::*;
(
    input  logic                       clk,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [COEF_W-1:0]   op_a,
    input  logic signed [SAMPLE_W-1:0] op_b,
    input  logic signed [ACC_W-1:0]    base,
    output logic signed [SAMPLE_W-1:0] sample
);

    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            acc_next;
    logic signed [COEF_W+SAMPLE_W-1:0]  product;
    logic signed [ACC_W-FRAC_W-1:0]     scaled;

    // one 16x16 multiply and accumulate per cycle while ctrl.en is set
    always_comb
    begin
        product  = op_a * op_b;
        acc_next = (ctrl.load ? base : acc_reg) + ACC_W'(product);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    // floor shift and saturate to 16 bits
    always_comb
    begin
        scaled = acc_reg[ACC_W-1:FRAC_W];
        if (scaled > (ACC_W-FRAC_W)'(SAMPLE_MAX))
        begin
            sample = SAMPLE_MAX;
        end
        else if (scaled < (ACC_W-FRAC_W)'(SAMPLE_MIN))
        begin
            sample = SAMPLE_MIN;
        end
        else
        begin
            sample = scaled[SAMPLE_W-1:0];
        end
    end

endmodule

// ----- sim/tb.sv -----
module tb;
    import dspad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int CLK_HALF     = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_WORDS  = 115;

    // one input word as queued for the driver
    typedef struct {
        logic [CMD_W-1:0]           cmd;
        logic [BYTE_W-1:0]          data_byte;
        logic signed [SAMPLE_W-1:0] init_newer;
        logic signed [SAMPLE_W-1:0] init_older;
    } in_word_t;

    // one decoded sample pair as expected on the output
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_high;
        logic signed [SAMPLE_W-1:0] sample_low;
        logic                       coef_error;
    } pair_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // tb-side drive registers, all known from time zero
    logic                       drv_valid = 1'b0;
    logic [CMD_W-1:0]           drv_cmd = '0;
    logic [BYTE_W-1:0]          drv_byte = '0;
    logic signed [SAMPLE_W-1:0] drv_newer = '0;
    logic signed [SAMPLE_W-1:0] drv_older = '0;
    logic                       mon_ready = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [PRED_W-1:0]          cfg_index = '0;
    logic [PAIR_W-1:0]          cfg_wdata = '0;

    dspad_in_if  item_bus ();
    dspad_out_if result_bus ();

    assign item_bus.valid      = drv_valid;
    assign item_bus.cmd        = drv_cmd;
    assign item_bus.data_byte  = drv_byte;
    assign item_bus.init_newer = drv_newer;
    assign item_bus.init_older = drv_older;
    assign result_bus.ready    = mon_ready;

    dsp_adpcm_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // decoder state mirrored by the testbench
    logic [PAIR_W-1:0]          coef_pair [NUM_PRED];
    logic signed [SAMPLE_W-1:0] hist_new;
    logic signed [SAMPLE_W-1:0] hist_old;
    logic [SHIFT_W-1:0]         shift_st;
    logic [PRED_W-1:0]          pred_st;
    logic                       bad_st;

    in_word_t   word_q [$];
    pair_word_t sample_q [$];
    in_word_t   cur_word;

    int  errors = 0;
    int  n_data = 0;
    int  n_hdr = 0;
    int  n_bad_hdr = 0;
    int  n_load = 0;
    int  n_spare = 0;
    int  n_results = 0;
    int  n_clamped = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    bit  idle_on = 1'b1;

    // clock and simulation timeout
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one nibble through the predictor; shifts the history
    function automatic logic signed [SAMPLE_W-1:0] decode_nibble(
        input logic [3:0]                nib,
        input logic signed [COEF_W-1:0]  c1,
        input logic signed [COEF_W-1:0]  c2
    );
        longint acc;
        longint q;
        logic signed [SAMPLE_W-1:0] s;
        acc = longint'($signed(nib)) * (longint'(1) << shift_st) * 2048;
        acc += 1024;
        acc += longint'(c1) * longint'(hist_new);
        acc += longint'(c2) * longint'(hist_old);
        q = acc >>> FRAC_W;
        if (q > 32767 || q < -32768)
            n_clamped++;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        s = q[SAMPLE_W-1:0];
        hist_old = hist_new;
        hist_new = s;
        return s;
    endfunction

    // apply one accepted word to the mirrored state, queue any result
    function automatic void decode_word(input in_word_t w);
        pair_word_t p;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        case (w.cmd)
            CMD_HEADER:
            begin
                n_hdr++;
                shift_st = w.data_byte[3:0];
                if (w.data_byte[7])
                begin
                    pred_st = PRED_W'(NUM_PRED - 1);
                    bad_st  = 1'b1;
                    n_bad_hdr++;
                end
                else
                begin
                    pred_st = w.data_byte[6:4];
                    bad_st  = 1'b0;
                end
            end
            CMD_DATA:
            begin
                n_data++;
                c1 = coef_pair[pred_st][PAIR_W-1:COEF_W];
                c2 = coef_pair[pred_st][COEF_W-1:0];
                p.sample_high = decode_nibble(w.data_byte[7:4], c1, c2);
                p.sample_low  = decode_nibble(w.data_byte[3:0], c1, c2);
                p.coef_error  = bad_st;
                sample_q.push_back(p);
            end
            CMD_LOAD:
            begin
                n_load++;
                hist_new = w.init_newer;
                hist_old = w.init_older;
            end
            default:
                n_spare++;
        endcase
    endfunction

    // input driver: one nonblocking write per signal per edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drv_valid && item_bus.ready)
                decode_word(cur_word);
            if (!drv_valid || item_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    cur_word = word_q.pop_front();
                    drv_cmd   <= cur_word.cmd;
                    drv_byte  <= cur_word.data_byte;
                    drv_newer <= cur_word.init_newer;
                    drv_older <= cur_word.init_older;
                    drv_valid <= 1'b1;
                    if (idle_on)
                        gap_left = gap_len();
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver back-pressure
    always @(posedge clk)
    begin
        pair_word_t want;
        if (rst_n)
        begin
            if (mon_ready && result_bus.valid)
            begin
                n_results++;
                if (sample_q.size() == 0)
                begin
                    $error("result word with no pending expectation");
                    errors++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (result_bus.sample_high !== want.sample_high)
                    begin
                        $error("sample_high expected %0d got %0d",
                               want.sample_high, result_bus.sample_high);
                        errors++;
                    end
                    if (result_bus.sample_low !== want.sample_low)
                    begin
                        $error("sample_low expected %0d got %0d",
                               want.sample_low, result_bus.sample_low);
                        errors++;
                    end
                    if (result_bus.coef_error !== want.coef_error)
                    begin
                        $error("coef_error expected %0d got %0d",
                               want.coef_error, result_bus.coef_error);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_seq)
            begin
                hold_seen  = hold_seq;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                mon_ready <= 1'b0;
            end
            else
            begin
                mon_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    task automatic push_word(
        input logic [CMD_W-1:0]           cmd,
        input logic [BYTE_W-1:0]          data_byte,
        input logic signed [SAMPLE_W-1:0] newer,
        input logic signed [SAMPLE_W-1:0] older
    );
        in_word_t w;
        w.cmd        = cmd;
        w.data_byte  = data_byte;
        w.init_newer = newer;
        w.init_older = older;
        word_q.push_back(w);
    endtask

    // register write; the enable is lowered by cfg_close
    task automatic cfg_write(input int idx, input logic [PAIR_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= PRED_W'(idx);
        cfg_wdata <= val;
        coef_pair[idx] = val;
    endtask

    task automatic cfg_close();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // all words sent, all results in, then the block's own latency
    task automatic wait_idle();
        do
            @(negedge clk);
        while (word_q.size() != 0 || drv_valid || sample_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [PAIR_W-1:0] rand_pair();
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        case ($urandom_range(0, 5))
            0: return 32'h7fff_7fff;
            1: return 32'h8000_8000;
            2: return 32'h0000_0000;
            3: return $urandom();
            default:
            begin
                // typical decoder coefficients: c1 in [0, 2], c2 in [-1, 0]
                c1 = COEF_W'($urandom_range(0, 4096));
                c2 = -COEF_W'($urandom_range(0, 2048));
                return {c1, c2};
            end
        endcase
    endfunction

    // random stimulus, mostly whole frames with random content
    task automatic gen_random(input int n_words);
        int cnt;
        int r;
        int k;
        int len;
        logic [3:0] idx;
        cnt = 0;
        while (cnt < n_words)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                idx = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 7))
                                                   : 4'($urandom_range(8, 15));
                push_word(CMD_HEADER, {idx, 4'($urandom())}, 16'($urandom()),
                          16'($urandom()));
                for (k = 0; k < 7; k++)
                    push_word(CMD_DATA, 8'($urandom()), 16'($urandom()),
                              16'($urandom()));
                cnt += 8;
            end
            else if (r < 80)
            begin
                push_word(CMD_LOAD, 8'($urandom()), 16'($urandom()), 16'($urandom()));
                cnt++;
            end
            else if (r < 90)
            begin
                // broken frame
                len = $urandom_range(0, 6);
                push_word(CMD_HEADER, 8'($urandom()), 16'($urandom()), 16'($urandom()));
                for (k = 0; k < len; k++)
                    push_word(CMD_DATA, 8'($urandom()), 16'($urandom()),
                              16'($urandom()));
                cnt += len + 1;
            end
            else if (r < 95)
            begin
                push_word(CMD_SPARE, 8'($urandom()), 16'($urandom()), 16'($urandom()));
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    push_word(CMD_DATA, 8'($urandom()), 16'($urandom()),
                              16'($urandom()));
                cnt += len;
            end
        end
    endtask

    // main sequence
    initial
    begin
        int ph;
        int i;
        for (i = 0; i < NUM_PRED; i++)
            coef_pair[i] = '0;
        hist_new = '0;
        hist_old = '0;
        shift_st = '0;
        pred_st  = '0;
        bad_st   = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // data before any header, reset coefficients
        push_word(CMD_DATA, 8'h00, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h7f, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h80, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'hff, 16'sh0000, 16'sh0000);
        wait_idle();

        // coefficient extremes
        cfg_write(0, 32'h7fff_7fff);
        cfg_write(1, 32'h8000_8000);
        cfg_write(2, 32'h7fff_8000);
        cfg_write(3, 32'h8000_7fff);
        cfg_write(4, 32'h0000_0000);
        cfg_write(5, 32'h0800_0000);
        cfg_write(6, 32'h1000_f800);
        cfg_write(7, 32'hffff_ffff);
        cfg_close();

        // new coefficients under the old header, then headers and loads
        push_word(CMD_DATA, 8'h12, 16'sh0000, 16'sh0000);
        push_word(CMD_HEADER, 8'h0f, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h77, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h88, 16'sh0000, 16'sh0000);
        push_word(CMD_LOAD, 8'h00, 16'sh7fff, 16'sh8000);
        push_word(CMD_HEADER, 8'h1f, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h80, 16'sh0000, 16'sh0000);
        push_word(CMD_HEADER, 8'hf3, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h5a, 16'sh0000, 16'sh0000);
        push_word(CMD_HEADER, 8'h9e, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'hc3, 16'sh0000, 16'sh0000);
        push_word(CMD_HEADER, 8'h70, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h11, 16'sh0000, 16'sh0000);
        push_word(CMD_SPARE, 8'hff, 16'shffff, 16'shffff);
        push_word(CMD_DATA, 8'h00, 16'sh0000, 16'sh0000);
        push_word(CMD_LOAD, 8'hff, 16'sh8000, 16'sh7fff);
        push_word(CMD_HEADER, 8'h25, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'hff, 16'sh0000, 16'sh0000);
        push_word(CMD_HEADER, 8'h3a, 16'sh0000, 16'sh0000);
        push_word(CMD_DATA, 8'h08, 16'sh0000, 16'sh0000);
        wait_idle();

        // random phases, each with its own coefficient set
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (i = 0; i < NUM_PRED; i++)
                cfg_write(i, rand_pair());
            cfg_close();
            idle_on = (ph != 2);
            gen_random(PHASE_WORDS);
            // long receiver hold while the sender keeps going
            if (ph == 3)
                hold_seq++;
            wait_idle();
        end

        // leave all registers at zero
        for (i = 0; i < NUM_PRED; i++)
            cfg_write(i, 32'h0000_0000);
        cfg_close();
        idle_on = 1'b1;
        gen_random(24);
        wait_idle();

        $display("tb: %0d data, %0d header (%0d bad index), %0d load, %0d unused words",
                 n_data, n_hdr, n_bad_hdr, n_load, n_spare);
        $display("tb: %0d sample pairs checked, %0d clamped samples, %0d mismatches",
                 n_results, n_clamped, errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
